>>> hw/rtl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg
// shared types and constants for the bounded ordered list
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    REQ_INS_HEAD = 2'd0,
    REQ_INS_TAIL = 2'd1,
    REQ_DELETE   = 2'd2,
    REQ_DUMP     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic ins_head;
    logic ins_tail;
    logic del;
    logic dump_rst;
    logic dump_adv;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_bad;
    logic dump_last;
  } stat_t;

endpackage

>>> hw/rtl/bol_datapath.sv
// ----------------------------------------------------------------------------
// bol_datapath
// shifting cell array, fill count and dump pointer
// ----------------------------------------------------------------------------
module bol_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bol_pkg::cmd_t              cmd_i,
  input  logic signed [31:0]         new_value_i,
  input  logic [4:0]                 position_i,
  output bol_pkg::stat_t             stat_o,
  output logic signed [31:0]         dump_value_o,
  output logic [bol_pkg::CntW-1:0]   count_o
);
  import bol_pkg::*;

  logic signed [31:0] cells_q [Capacity];
  logic [CntW-1:0]    count_q;
  logic [IdxW-1:0]    rd_q;
  logic [IdxW-1:0]    del_idx;
  logic [4:0]         pos_m1;

  assign pos_m1  = position_i - 5'd1;
  assign del_idx = IdxW'(pos_m1);

  // each cell shifts from its neighbor on head insert and delete
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Capacity; i++) begin
      if (cmd_i.ins_head) begin
        if (i == 0) cells_q[i] <= new_value_i;
        else        cells_q[i] <= cells_q[i-1];
      end else if (cmd_i.ins_tail) begin
        if (CntW'(i) == count_q) cells_q[i] <= new_value_i;
      end else if (cmd_i.del) begin
        if (i < Capacity - 1 && IdxW'(i) >= del_idx) cells_q[i] <= cells_q[i+1];
      end
    end
  end

  // fill count and dump pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= '0;
    end else begin
      if (cmd_i.ins_head || cmd_i.ins_tail) count_q <= count_q + CntW'(1);
      else if (cmd_i.del)                   count_q <= count_q - CntW'(1);
      if (cmd_i.dump_rst)      rd_q <= '0;
      else if (cmd_i.dump_adv) rd_q <= rd_q + IdxW'(1);
    end
  end

  assign stat_o.full      = (count_q == CntW'(Capacity));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.pos_bad   = (position_i == 5'd0) || (CntW'(position_i) > count_q) ||
                            (position_i > 5'(Capacity));
  assign stat_o.dump_last = (CntW'(rd_q) + CntW'(1) == count_q);
  assign dump_value_o     = cells_q[rd_q];
  assign count_o          = count_q;
endmodule

>>> hw/rtl/bol_ctrl.sv
// ----------------------------------------------------------------------------
// bol_ctrl
// request sequencer and output register
// ----------------------------------------------------------------------------
module bol_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [31:0]       item_value_o,
  output logic [1:0]               status_o,
  output logic                     last_item_o,
  output logic [4:0]               entry_count_o,
  output bol_pkg::cmd_t            cmd_o,
  input  bol_pkg::stat_t           stat_i,
  input  logic signed [31:0]       dump_value_i,
  input  logic [bol_pkg::CntW-1:0] count_i
);
  import bol_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   ov_q;
  logic   slot_free, accept, dump_emit;
  logic signed [31:0] val_q;
  logic [1:0] st_q;
  logic last_q;
  logic [4:0] cnt_q;
  req_e req;

  assign req        = req_e'(req_type_i);
  assign slot_free  = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign dump_emit  = (state_q == S_DUMP) && slot_free;

  // commands to the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.ins_head = accept && req == REQ_INS_HEAD && !stat_i.full;
    cmd_o.ins_tail = accept && req == REQ_INS_TAIL && !stat_i.full;
    cmd_o.del      = accept && req == REQ_DELETE && !stat_i.pos_bad;
    cmd_o.dump_rst = accept && req == REQ_DUMP;
    cmd_o.dump_adv = dump_emit;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && req == REQ_DUMP && !stat_i.empty) state_d = S_DUMP;
      S_DUMP: if (dump_emit && stat_i.dump_last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && !(req == REQ_DUMP && !stat_i.empty)) ov_q <= 1'b1;
      else if (dump_emit)                                ov_q <= 1'b1;
      else if (!out_stall_i)                             ov_q <= 1'b0;
    end
  end

  // output item register
  always_ff @(posedge clk_i) begin
    if (dump_emit) begin
      val_q  <= dump_value_i;
      st_q   <= ST_OK;
      last_q <= stat_i.dump_last;
      cnt_q  <= 5'(count_i);
    end else if (accept) begin
      val_q  <= '0;
      last_q <= 1'b1;
      unique case (req)
        REQ_INS_HEAD, REQ_INS_TAIL: begin
          st_q  <= stat_i.full ? ST_FULL : ST_OK;
          cnt_q <= stat_i.full ? 5'(count_i) : 5'(count_i + CntW'(1));
        end
        REQ_DELETE: begin
          st_q  <= stat_i.pos_bad ? ST_BADPOS : ST_OK;
          cnt_q <= stat_i.pos_bad ? 5'(count_i) : 5'(count_i - CntW'(1));
        end
        REQ_DUMP: begin
          st_q  <= ST_EMPTY;
          cnt_q <= 5'(count_i);
        end
        default: st_q <= ST_OK;
      endcase
    end
  end

  assign out_valid_o   = ov_q;
  assign item_value_o  = val_q;
  assign status_o      = st_q;
  assign last_item_o   = last_q;
  assign entry_count_o = cnt_q;

  // no request taken during a dump
  a_no_accept_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> !accept) else $error("accept during dump");
  // count within capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_i <= CntW'(Capacity)) else $error("count overflow");
  // a dump never runs on an empty list
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> !stat_i.empty) else $error("dump of empty list");
endmodule

>>> hw/rtl/bounded_ordered_list.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list
// ordered list of signed values with head/tail insert, delete and dump
// ----------------------------------------------------------------------------
// Insert and delete requests update the cells in place and produce one status
// item. A dump produces one item per entry (ST_EMPTY if none), one per cycle
// when the output does not stall, stalling the input until the last entry;
// the dump pointer walks the cell array. Output stall stretches all of this.
module bounded_ordered_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] new_value_i,
  input  logic [4:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] item_value_o,
  output logic [1:0]         status_o,
  output logic               last_item_o,
  output logic [4:0]         entry_count_o
);
  import bol_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic signed [31:0] dump_value;
  logic [CntW-1:0]    count;

  bol_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i,
    .out_valid_o, .out_stall_i, .item_value_o, .status_o, .last_item_o,
    .entry_count_o, .cmd_o(cmd), .stat_i(stat), .dump_value_i(dump_value),
    .count_i(count)
  );

  bol_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .new_value_i, .position_i,
    .stat_o(stat), .dump_value_o(dump_value), .count_o(count)
  );
endmodule
